// ----- design/kmer_window_matcher_macros.svh -----
// ----------------------------------------------------------------------------
// kmer_window_matcher_macros.svh
// Assertion macros used by the matcher design file.
// ----------------------------------------------------------------------------
`ifndef KMER_WINDOW_MATCHER_MACROS_SVH
`define KMER_WINDOW_MATCHER_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define KWM_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define KWM_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define KWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/kwm_pkg.sv -----
// ----------------------------------------------------------------------------
// kwm_pkg
// Sizes, register indexes and result type of the k-mer window matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kwm_pkg;

  // Storage sizes
  localparam int RefDepth  = 64;
  localparam int MaxWindow = 16;

  // Field widths
  localparam int SymW    = 8;
  localparam int PosW    = 6;
  localparam int RowW    = 16;
  localparam int MaskW   = 64;
  localparam int CountW  = 7;
  localparam int WinLenW = 5;
  localparam int BLenW   = 7;

  // Derived widths
  localparam int RefIdxW = (RefDepth > 1) ? $clog2(RefDepth) : 1;
  localparam int WinIdxW = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;
  localparam int KW      = $clog2(MaxWindow + 1);

  // Popcount is split into groups of mask bits
  localparam int GroupW    = 8;
  localparam int NumGroups = MaskW / GroupW;
  localparam int GroupCntW = $clog2(GroupW + 1);

  // Stream and register port widths
  localparam int InDataW  = 16;
  localparam int OutDataW = 88;
  localparam int PaddrW   = 3;
  localparam int PdataW   = 32;

  // Register index, taken from paddr bit 2
  localparam logic RegWindowLen = 1'b0;
  localparam logic RegBLength   = 1'b1;

  // One buffered result
  typedef struct packed {
    logic [RowW-1:0]                      row;
    logic [MaskW-1:0]                     mask;
    logic [NumGroups-1:0][GroupCntW-1:0]  part_cnt;
  } kwm_result_t;

endpackage

// ----- design/kmer_window_matcher.sv -----
// ----------------------------------------------------------------------------
// kmer_window_matcher
// Brute-force fixed-length substring matcher: loads a reference string, then
// compares every query window of length k against all reference positions.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Carries
//  ---------+-----------+------------------------------------------------------
//  s_axis   | in        | reference load or query symbol, one per beat
//  m_axis   | out       | row index, match mask and match count, one per beat
//  APB      | in/out    | window_len at 0x0, b_length at 0x4
//
//  One beat is taken every cycle while s_axis_tready is high; a query result
//  is registered into the output register, or the skid entry if that is held.
//  The comparator array (64 positions by 16 window symbols) is combinational.
//  Reset clears the window, fill level, row counter and registers; the
//  reference store is not cleared and must be loaded before use.
//  A two-entry output buffer absorbs stalls; s_axis_tready drops only when
//  both entries hold results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "kmer_window_matcher_macros.svh"

module kmer_window_matcher (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] symbol, [13:8] ref_position, [14] query_restart, [15] zero
  input  logic [kwm_pkg::InDataW-1:0]   s_axis_tdata,
  // [0] req_type
  input  logic                          s_axis_tuser,
  // Result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [15:0] row_index, [79:16] match_mask, [86:80] match_count, [87] zero
  output logic [kwm_pkg::OutDataW-1:0]  m_axis_tdata,
  // Register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kwm_pkg::PaddrW-1:0]    paddr,
  input  logic [kwm_pkg::PdataW-1:0]    pwdata,
  output logic [kwm_pkg::PdataW-1:0]    prdata,
  output logic                          pready
);

  import kwm_pkg::*;

  // Registers
  logic [WinLenW-1:0] cfg_window_len_q, cfg_window_len_d;
  logic [BLenW-1:0]   cfg_b_length_q, cfg_b_length_d;
  logic               cfg_wr;

  // Input beat
  logic               in_acc, load_acc, query_acc;
  logic [SymW-1:0]    in_sym;
  logic [PosW-1:0]    in_pos;
  logic               in_restart;

  // Matcher state
  logic [SymW-1:0]    ref_store_q [RefDepth];
  logic [SymW-1:0]    window_q [MaxWindow];
  logic [SymW-1:0]    window_d [MaxWindow];
  logic [KW-1:0]      fill_q, fill_d, fill_base;
  logic [RowW-1:0]    row_q, row_d, row_base;

  // Compare path
  logic [KW-1:0]      k_eff;
  logic [BLenW-1:0]   blen_eff;
  logic [KW-1:0]      al_idx;
  logic [SymW-1:0]    q_al [MaxWindow];
  logic               match_hit;
  logic [MaskW-1:0]   mask;
  logic               has_result;
  kwm_result_t        res_new;

  // Output buffer
  kwm_result_t        out_q, out_d, skid_q, skid_d;
  logic               out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic               push, pop;
  logic [CountW-1:0]  out_count;

  // Register writes and reads
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cfg_window_len_d = cfg_window_len_q;
    cfg_b_length_d   = cfg_b_length_q;
    if (cfg_wr) begin
      case (paddr[2])
        RegWindowLen: cfg_window_len_d = pwdata[WinLenW-1:0];
        RegBLength:   cfg_b_length_d   = pwdata[BLenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegWindowLen: prdata = PdataW'(cfg_window_len_q);
      RegBLength:   prdata = PdataW'(cfg_b_length_q);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_window_len_q <= WinLenW'(1);
      cfg_b_length_q   <= '0;
    end else begin
      cfg_window_len_q <= cfg_window_len_d;
      cfg_b_length_q   <= cfg_b_length_d;
    end
  end

  // Clamp window and reference lengths to the supported range
  always_comb begin
    if (32'(cfg_window_len_q) > MaxWindow) begin
      k_eff = KW'(MaxWindow);
    end else if (cfg_window_len_q == '0) begin
      k_eff = KW'(1);
    end else begin
      k_eff = KW'(cfg_window_len_q);
    end
    if (32'(cfg_b_length_q) > RefDepth) begin
      blen_eff = BLenW'(RefDepth);
    end else begin
      blen_eff = cfg_b_length_q;
    end
  end

  // Unpack the input beat
  assign in_sym     = s_axis_tdata[SymW-1:0];
  assign in_pos     = s_axis_tdata[SymW +: PosW];
  assign in_restart = s_axis_tdata[SymW+PosW];
  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign load_acc   = in_acc && !s_axis_tuser;
  assign query_acc  = in_acc && s_axis_tuser;

  // Write a reference symbol; positions beyond the store are dropped
  always_ff @(posedge clk_i) begin
    if (load_acc && (32'(in_pos) < RefDepth)) begin
      ref_store_q[in_pos[RefIdxW-1:0]] <= in_sym;
    end
  end

  // Shift the new query symbol in at the newest end
  always_comb begin
    window_d[0] = in_sym;
    for (int i = 1; i < MaxWindow; i++) begin
      window_d[i] = window_q[i-1];
    end
  end

  // Fill level and row counter, restarted by a new query string
  always_comb begin
    fill_base = in_restart ? '0 : fill_q;
    row_base  = in_restart ? '0 : row_q;
    if (32'(fill_base) < MaxWindow) begin
      fill_d = fill_base + KW'(1);
    end else begin
      fill_d = fill_base;
    end
    has_result = (fill_d >= k_eff);
    row_d      = has_result ? row_base + RowW'(1) : row_base;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxWindow; i++) begin
        window_q[i] <= '0;
      end
      fill_q <= '0;
      row_q  <= '0;
    end else if (query_acc) begin
      window_q <= window_d;
      fill_q   <= fill_d;
      row_q    <= row_d;
    end
  end

  // Align the window oldest-first over its k symbols
  always_comb begin
    al_idx = '0;
    for (int i = 0; i < MaxWindow; i++) begin
      q_al[i] = '0;
      if (32'(i) < 32'(k_eff)) begin
        al_idx  = k_eff - KW'(i) - KW'(1);
        q_al[i] = window_d[al_idx[WinIdxW-1:0]];
      end
    end
  end

  // Compare the window against every reference start in parallel
  always_comb begin
    match_hit = 1'b0;
    for (int j = 0; j < MaskW; j++) begin
      match_hit = (j < RefDepth) && (32'(j) + 32'(k_eff) <= 32'(blen_eff));
      for (int i = 0; i < MaxWindow; i++) begin
        if (32'(i) < 32'(k_eff)) begin
          if (j + i < RefDepth) begin
            match_hit = match_hit &&
                        (ref_store_q[RefIdxW'((j + i) % RefDepth)] == q_al[i]);
          end else begin
            match_hit = 1'b0;
          end
        end
      end
      mask[j] = match_hit;
    end
  end

  // Count matches per group of mask bits
  always_comb begin
    res_new.row  = row_base;
    res_new.mask = mask;
    for (int g = 0; g < NumGroups; g++) begin
      res_new.part_cnt[g] = '0;
      for (int b = 0; b < GroupW; b++) begin
        res_new.part_cnt[g] = res_new.part_cnt[g] + GroupCntW'(mask[g*GroupW+b]);
      end
    end
  end

  // Two-entry output buffer: output register plus skid entry
  assign push = query_acc && has_result;
  assign pop  = out_valid_q && m_axis_tready;

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_d       = res_new;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res_new;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  // Finish the popcount from the group counts
  always_comb begin
    out_count = '0;
    for (int g = 0; g < NumGroups; g++) begin
      out_count = out_count + CountW'(out_q.part_cnt[g]);
    end
  end

  // Drive the stream ports
  assign s_axis_tready = !skid_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW-RowW-MaskW-CountW){1'b0}},
                          out_count, out_q.mask, out_q.row};

  // Assertions
  `KWM_ASSERT_IMPLIES(a_skid_needs_out, skid_valid_q, out_valid_q, "skid entry without output")
  `KWM_ASSERT_IMPLIES(a_count_matches_mask, out_valid_q,
                      32'(out_count) == $countones(out_q.mask), "match count off")
  `KWM_ASSERT_ALWAYS(a_fill_bounded, 32'(fill_q) <= MaxWindow, "window fill overflow")
  `KWM_ASSERT_NEXT(a_restart_row, query_acc && in_restart, row_q <= RowW'(1),
                   "row counter not restarted")

endmodule
